/* sv/ggnh_pkg.sv */
// Shared types and constants for the greedy geographic next-hop block.
package ggnh_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ROUTERS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths of the input and result words.
    localparam int IDX_FIELD_W   = 6;
    localparam int COORD_FIELD_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int RANGE_W    = 16;
    localparam int ACTIVE_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_RANGE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROUTERS = 1'b1;

    localparam logic [RANGE_W-1:0]  RADIO_RANGE_RST    = 16'd100;
    localparam logic [ACTIVE_W-1:0] ACTIVE_ROUTERS_RST = 7'd0;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_FIELD_W-1:0]   router_index;
        logic [COORD_FIELD_W-1:0] pos_x;
        logic [COORD_FIELD_W-1:0] pos_y;
        logic [IDX_FIELD_W-1:0]   target_index;
    } t_in_word;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] next_hop;
        logic                   found;
        logic                   reached_target;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_TGT,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

/* sv/greedy_geographic_next_hop_top.sv */
// Top level of the greedy geographic next-hop selector: coordinate table, scan and result.
//
// This block keeps a table of router coordinates in one synchronous memory and answers
// next-hop queries. A load word (req_type 0) writes one entry and is finished in the
// cycle it is accepted; it gives no result. A query word (req_type 1) names the current
// router and the target. The block first reads the current and target coordinates, then
// walks the active entries from index zero, one memory read per cycle, through a short
// pipeline: absolute differences, squares, then a sum, compare and best-so-far update.
// A router is a neighbour when its squared distance to the current router is at most
// radio_range squared. A neighbour that is the target wins outright; otherwise the
// neighbour nearest the target wins, lowest index first on ties. If nothing is in range
// the result word has all fields zero. A query occupies the block through two set-up
// reads, one read per scanned entry, the pipeline drain and the hand-off to the output
// register; the single memory read port serves these reads one after another.
// The block takes one word at a time and holds o_in_stall high while a
// query is in flight. The finished result sits in an output register, so the next word
// is accepted while a result still waits to be taken. Entries must be loaded before a
// query reads them; the table has no reset and no clearing pass. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module greedy_geographic_next_hop_top #(
    parameter int MAX_ROUTERS = ggnh_pkg::MAX_ROUTERS_DEF,
    parameter int COORD_BITS  = ggnh_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ggnh_pkg::t_in_word                 i_in,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ggnh_pkg::t_out_word                o_out,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [ggnh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ggnh_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_ROUTERS);
    localparam int CNT_W  = $clog2(MAX_ROUTERS + 1);
    localparam int CW     = COORD_BITS;
    localparam int SQ_W   = 2 * CW;
    localparam int CMP_W  = (SQ_W + 1 > 32) ? SQ_W + 1 : 32;

    // Configuration registers.
    logic [ggnh_pkg::RANGE_W-1:0]  r_radio;
    logic [ggnh_pkg::ACTIVE_W-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radio  <= ggnh_pkg::RADIO_RANGE_RST;
            r_active <= ggnh_pkg::ACTIVE_ROUTERS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ggnh_pkg::CFG_RADIO_RANGE:    r_radio  <= i_cfg_data;
                ggnh_pkg::CFG_ACTIVE_ROUTERS: r_active <= i_cfg_data[ggnh_pkg::ACTIVE_W-1:0];
            endcase
        end
    end

    // Input decode. Indices are widened to 32 bits so that the range checks and the
    // address slices hold for any table depth.
    logic            in_acc;
    logic            load_acc;
    logic            query_acc;
    logic [31:0]     in_cur_ext;
    logic [31:0]     in_tgt_ext;
    logic [31:0]     in_x_ext;
    logic [31:0]     in_y_ext;
    logic            cur_ok;
    logic            tgt_ok;
    logic [31:0]     act_ext;
    logic [31:0]     lim_ext;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_acc   = in_acc && (i_in.req_type == ggnh_pkg::REQ_LOAD);
    assign query_acc  = in_acc && (i_in.req_type == ggnh_pkg::REQ_QUERY);
    assign in_cur_ext = 32'(i_in.router_index);
    assign in_tgt_ext = 32'(i_in.target_index);
    assign in_x_ext   = 32'(i_in.pos_x);
    assign in_y_ext   = 32'(i_in.pos_y);
    assign cur_ok     = in_cur_ext < 32'(MAX_ROUTERS);
    assign tgt_ok     = in_tgt_ext < 32'(MAX_ROUTERS);
    assign act_ext    = 32'(r_active);
    assign lim_ext    = (act_ext > 32'(MAX_ROUTERS)) ? 32'(MAX_ROUTERS) : act_ext;

    // Sequencer state.
    ggnh_pkg::t_state r_state;
    ggnh_pkg::t_state n_state;
    logic [CNT_W-1:0] r_scan;
    logic [CNT_W-1:0] n_scan;
    logic [CNT_W:0]   scan_inc;
    logic [IDX_W-1:0] rd_addr;
    logic             issue;
    logic             finish;

    // Query context: set when the query is accepted, coordinates from the set-up reads.
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_tgt;
    logic [CNT_W-1:0] r_limit;
    logic [31:0]      r_range_sq;
    logic [CW-1:0]    r_cur_x;
    logic [CW-1:0]    r_cur_y;
    logic [CW-1:0]    r_tgt_x;
    logic [CW-1:0]    r_tgt_y;

    // Pipeline registers.
    logic             r_rd_is_cur;
    logic             r_rd_is_tgt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [SQ_W-1:0]  r_rd_data;
    logic             r_df_vld;
    logic [IDX_W-1:0] r_df_idx;
    logic [CW-1:0]    r_dxc;
    logic [CW-1:0]    r_dyc;
    logic [CW-1:0]    r_dxt;
    logic [CW-1:0]    r_dyt;
    logic             r_sq_vld;
    logic [IDX_W-1:0] r_sq_idx;
    logic [SQ_W-1:0]  r_sqxc;
    logic [SQ_W-1:0]  r_sqyc;
    logic [SQ_W-1:0]  r_sqxt;
    logic [SQ_W-1:0]  r_sqyt;

    // Running decision.
    logic             r_have;
    logic             r_reached;
    logic [IDX_W-1:0] r_best;
    logic [CMP_W-1:0] r_best_d;

    // Result register.
    logic                r_out_vld;
    ggnh_pkg::t_out_word r_out;

    // Coordinate table: x in the upper half of each word, y in the lower half.
    logic [SQ_W-1:0] r_coord_mem [MAX_ROUTERS];

    always_ff @(posedge i_clk) begin
        if (load_acc && cur_ok) begin
            r_coord_mem[in_cur_ext[IDX_W-1:0]] <= {in_x_ext[CW-1:0], in_y_ext[CW-1:0]};
        end
        r_rd_data <= r_coord_mem[rd_addr];
    end

    // Next state, read address and scan control.
    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        rd_addr  = r_scan[IDX_W-1:0];
        issue    = 1'b0;
        finish   = 1'b0;
        scan_inc = {1'b0, r_scan} + 1'b1;
        unique case (r_state)
            ggnh_pkg::ST_IDLE: begin
                n_scan = '0;
                if (query_acc) begin
                    // A query naming an index beyond the table skips the reads and answers not found.
                    n_state = (cur_ok && tgt_ok) ? ggnh_pkg::ST_RD_CUR : ggnh_pkg::ST_DRAIN;
                end
            end
            ggnh_pkg::ST_RD_CUR: begin
                rd_addr = r_cur;
                n_state = ggnh_pkg::ST_RD_TGT;
            end
            ggnh_pkg::ST_RD_TGT: begin
                rd_addr = r_tgt;
                n_state = ggnh_pkg::ST_SCAN;
            end
            ggnh_pkg::ST_SCAN: begin
                issue = r_scan < r_limit;
                if (issue) begin
                    n_scan = scan_inc[CNT_W-1:0];
                end
                if (scan_inc >= {1'b0, r_limit}) begin
                    n_state = ggnh_pkg::ST_DRAIN;
                end
            end
            ggnh_pkg::ST_DRAIN: begin
                if (!r_rd_vld && !r_df_vld && !r_sq_vld && (!r_out_vld || !i_out_stall)) begin
                    finish  = 1'b1;
                    n_state = ggnh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ggnh_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ggnh_pkg::ST_IDLE);

    // Compare stage: both squared distances and the neighbour test.
    logic [CMP_W-1:0] d_cur;
    logic [CMP_W-1:0] d_tgt;
    logic             cand;

    assign d_cur = CMP_W'(r_sqxc) + CMP_W'(r_sqyc);
    assign d_tgt = CMP_W'(r_sqxt) + CMP_W'(r_sqyt);
    assign cand  = r_sq_vld && (r_sq_idx != r_cur) && (d_cur <= CMP_W'(r_range_sq));

    // Result selection at the end of a query.
    logic [IDX_W-1:0] sel_idx;
    logic [31:0]      sel_ext;

    assign sel_idx = r_reached ? r_tgt : (r_have ? r_best : '0);
    assign sel_ext = 32'(sel_idx);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ggnh_pkg::ST_IDLE;
            r_scan      <= '0;
            r_rd_is_cur <= 1'b0;
            r_rd_is_tgt <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_df_vld    <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_have      <= 1'b0;
            r_reached   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_rd_is_cur <= (r_state == ggnh_pkg::ST_RD_CUR);
            r_rd_is_tgt <= (r_state == ggnh_pkg::ST_RD_TGT);
            r_rd_vld    <= issue;
            r_df_vld    <= r_rd_vld;
            r_sq_vld    <= r_df_vld;

            if (query_acc) begin
                r_have    <= 1'b0;
                r_reached <= 1'b0;
            end else if (cand) begin
                // The target in range decides the query; later updates of the best
                // candidate no longer matter.
                if (r_sq_idx == r_tgt) begin
                    r_reached <= 1'b1;
                end else if (!r_have || d_tgt < r_best_d) begin
                    r_have <= 1'b1;
                end
            end

            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_cur      <= in_cur_ext[IDX_W-1:0];
            r_tgt      <= in_tgt_ext[IDX_W-1:0];
            r_limit    <= lim_ext[CNT_W-1:0];
            r_range_sq <= 32'(r_radio) * 32'(r_radio);
        end
        if (r_rd_is_cur) begin
            r_cur_x <= r_rd_data[SQ_W-1:CW];
            r_cur_y <= r_rd_data[CW-1:0];
        end
        if (r_rd_is_tgt) begin
            r_tgt_x <= r_rd_data[SQ_W-1:CW];
            r_tgt_y <= r_rd_data[CW-1:0];
        end

        r_rd_idx <= r_scan[IDX_W-1:0];

        // Difference stage.
        r_df_idx <= r_rd_idx;
        r_dxc <= (r_rd_data[SQ_W-1:CW] >= r_cur_x) ? r_rd_data[SQ_W-1:CW] - r_cur_x
                                                    : r_cur_x - r_rd_data[SQ_W-1:CW];
        r_dyc <= (r_rd_data[CW-1:0] >= r_cur_y) ? r_rd_data[CW-1:0] - r_cur_y
                                                : r_cur_y - r_rd_data[CW-1:0];
        r_dxt <= (r_rd_data[SQ_W-1:CW] >= r_tgt_x) ? r_rd_data[SQ_W-1:CW] - r_tgt_x
                                                    : r_tgt_x - r_rd_data[SQ_W-1:CW];
        r_dyt <= (r_rd_data[CW-1:0] >= r_tgt_y) ? r_rd_data[CW-1:0] - r_tgt_y
                                                : r_tgt_y - r_rd_data[CW-1:0];

        // Square stage.
        r_sq_idx <= r_df_idx;
        r_sqxc   <= SQ_W'(r_dxc) * SQ_W'(r_dxc);
        r_sqyc   <= SQ_W'(r_dyc) * SQ_W'(r_dyc);
        r_sqxt   <= SQ_W'(r_dxt) * SQ_W'(r_dxt);
        r_sqyt   <= SQ_W'(r_dyt) * SQ_W'(r_dyt);

        if (cand && r_sq_idx != r_tgt && (!r_have || d_tgt < r_best_d)) begin
            r_best   <= r_sq_idx;
            r_best_d <= d_tgt;
        end

        if (finish) begin
            r_out.next_hop       <= sel_ext[ggnh_pkg::IDX_FIELD_W-1:0];
            r_out.found          <= r_reached || r_have;
            r_out.reached_target <= r_reached;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_df_vld || r_sq_vld) |->
            (r_state == ggnh_pkg::ST_SCAN || r_state == ggnh_pkg::ST_DRAIN))
        else $error("scan pipeline busy outside a query");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ggnh_pkg::ST_SCAN) |-> (r_scan <= r_limit))
        else $error("scan counter ran past the active entries");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> (r_state == ggnh_pkg::ST_RD_CUR || r_state == ggnh_pkg::ST_DRAIN))
        else $error("accepted query did not start");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |->
            (o_out.next_hop == '0 && !o_out.reached_target))
        else $error("not-found result carries nonzero fields");

    a_reached_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.reached_target) |-> o_out.found)
        else $error("target reached without a found hop");
`endif

endmodule
